[rtl/rccv_pkg.sv]
// Shared types and constants for the RC channel validator with failsafe.
// Used by the top level and by the iterative divider; depends on nothing.
package rccv_pkg;

  localparam int PULSE_W = 12;
  localparam int DVD_W   = 19;  // magnitude of (pulse difference * 100)
  localparam int DVS_W   = 11;  // stick range or the fixed throttle span
  localparam int CNT_W   = 5;

  localparam logic [PULSE_W-1:0] PULSE_MIN_US     = 12'd800;
  localparam logic [PULSE_W-1:0] PULSE_MAX_US     = 12'd2200;
  localparam logic [PULSE_W-1:0] THROTTLE_ZERO_US = 12'd1000;
  localparam logic [DVS_W-1:0]   THROTTLE_SPAN_US = 11'd1000;
  localparam logic [6:0]         FULL_PERCENT     = 7'd100;

  typedef enum logic [1:0] {
    ACT_PULSE = 2'd0,
    ACT_ON    = 2'd1,
    ACT_OFF   = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_ON       = 2'd1,
    ST_FAILSAFE = 2'd2
  } status_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/rccv_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses the request and response structs from rccv_pkg.
module rccv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rccv_pkg::div_req_t div_req,
  output rccv_pkg::div_rsp_t div_rsp
);
  import rccv_pkg::*;

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        dvd_r  <= div_req.dividend;
        dvs_r  <= div_req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // The quotient bits shift into the dividend register from the right.
        dvd_r <= {dvd_r[DVD_W-2:0], fits};
        rem_r <= fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = dvd_r;

endmodule

[rtl/rc_channel_validate_failsafe_top.sv]
// RC channel validator with failsafe: top level with state update and sequencer.
// Each accepted input word runs through five sequencer steps, one of them waiting out the 19
// iterations of the shared radix-2 divider, to its registered result word, one word at a time.
// A new word is accepted only once the previous result word is loaded; output stalls delay that.
// Reset (synchronous, rst_n low) restores register defaults, clears all channels,
// turns the radio off and zeroes the silence counter.
module rc_channel_validate_failsafe_top #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_channel,
  input  logic [11:0] in_pulse_us,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel_out,
  output logic [11:0] out_value_us,
  output logic signed [7:0] out_percent,
  output logic [1:0]  out_status,
  output logic        out_disarm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rccv_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [2:0] CFG_SCENTER  = 3'd1;
  localparam logic [2:0] CFG_SRANGE   = 3'd2;
  localparam logic [2:0] CFG_TCENTER  = 3'd3;
  localparam logic [2:0] CFG_THR_IDX  = 3'd4;

  localparam logic signed [19:0] PCT_SCALE = 20'sd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_OUT
  } seq_t;

  // Configuration registers
  logic [15:0] timeout_r;
  logic [11:0] scenter_r;
  logic [10:0] srange_r;
  logic [11:0] tcenter_r;
  logic [2:0]  thr_idx_r;

  // Radio state
  logic [11:0] held_r   [CHANNELS];
  logic [11:0] held_nxt [CHANNELS];
  status_t     status_r, status_nxt;
  logic        fhv_r, fhv_nxt;
  logic [15:0] silence_r, silence_nxt;
  logic        disarm_nxt;

  // Item in flight
  seq_t        seq_r;
  action_t     act_r;
  logic [2:0]  ch_r;
  logic [11:0] pulse_r;
  logic        fend_r;
  logic [11:0] value_r;
  logic        disarm_r;
  logic        report_r;
  logic        neg_r;
  logic [DVD_W-1:0] mag_r;
  logic [DVS_W-1:0] dvs_r;

  logic             out_valid_r;
  logic [2:0]       out_ch_r;
  logic [11:0]      out_value_r;
  logic signed [7:0] out_pct_r;
  logic [1:0]       out_status_r;
  logic             out_disarm_r;

  logic [IDX_W-1:0] ch_idx;
  logic             ch_ok;
  logic             is_thr;
  logic             in_range;
  logic [11:0]      report_val;
  logic signed [12:0] diff;
  logic signed [19:0] prod;
  logic [DVD_W-1:0] mag_nxt;
  logic [DVS_W-1:0] dvs_nxt;
  logic [6:0]       mag_c;
  logic signed [7:0] pct;
  logic             out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign ch_idx   = IDX_W'(ch_r);
  assign ch_ok    = 32'(ch_r) < CHANNELS;
  assign is_thr   = ch_ok && (ch_r == thr_idx_r);
  assign in_range = (pulse_r >= PULSE_MIN_US) && (pulse_r <= PULSE_MAX_US);

  // State update for one word, following the sample, frame close, power and silence tick rules.
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      held_nxt[i] = held_r[i];
    end
    status_nxt  = status_r;
    fhv_nxt     = fhv_r;
    silence_nxt = silence_r;
    disarm_nxt  = 1'b0;
    unique case (act_r)
      ACT_PULSE: begin
        if (status_r != ST_OFF) begin
          if (ch_ok) begin
            priority if (in_range) begin
              held_nxt[ch_idx] = pulse_r;
              fhv_nxt          = 1'b1;
            end else if (held_r[ch_idx] == '0) begin
              held_nxt[ch_idx] = is_thr ? tcenter_r : scenter_r;
            end else begin
              held_nxt[ch_idx] = held_r[ch_idx];
            end
          end
          if (fend_r) begin
            priority if (fhv_nxt) begin
              silence_nxt = '0;
              if (status_r == ST_FAILSAFE) begin
                status_nxt = ST_ON;
              end
            end else if (silence_r > timeout_r && status_r != ST_FAILSAFE) begin
              status_nxt = ST_FAILSAFE;
              disarm_nxt = 1'b1;
              for (int i = 0; i < CHANNELS; i++) begin
                held_nxt[i] = '0;
              end
            end else begin
              status_nxt = status_r;
            end
            fhv_nxt = 1'b0;
          end
        end
      end
      ACT_ON: begin
        if (status_r == ST_OFF) begin
          status_nxt  = ST_ON;
          silence_nxt = '0;
          fhv_nxt     = 1'b0;
        end
      end
      ACT_OFF: begin
        if (status_r != ST_OFF) begin
          status_nxt  = ST_OFF;
          silence_nxt = '0;
          fhv_nxt     = 1'b0;
          for (int i = 0; i < CHANNELS; i++) begin
            held_nxt[i] = '0;
          end
        end
      end
      ACT_TICK: begin
        if (status_r != ST_OFF && silence_r != 16'hFFFF) begin
          silence_nxt = silence_r + 16'd1;
        end
      end
      default: begin
        silence_nxt = silence_r;
      end
    endcase
  end

  assign report_val = (status_nxt == ST_ON && ch_ok) ? held_nxt[ch_idx] : 12'd0;

  // Scaled difference and divisor; the sign is applied after the unsigned divide.
  assign diff    = $signed({1'b0, value_r}) -
                   $signed({1'b0, (is_thr ? THROTTLE_ZERO_US : scenter_r)});
  assign prod    = 20'(diff) * PCT_SCALE;
  assign mag_nxt = prod[19] ? DVD_W'(-prod) : prod[DVD_W-1:0];
  assign dvs_nxt = is_thr ? THROTTLE_SPAN_US :
                   ((srange_r == '0) ? DVS_W'(1) : srange_r);

  assign mag_c = (div_rsp.quotient > DVD_W'(FULL_PERCENT)) ? FULL_PERCENT :
                 div_rsp.quotient[6:0];

  always_comb begin
    if (!report_r) begin
      pct = '0;
    end else if (is_thr) begin
      pct = neg_r ? 8'sd0 : $signed({1'b0, mag_c});
    end else begin
      pct = neg_r ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    end
  end

  assign out_free = !(out_valid_r && out_stall);

  assign div_req.start    = (seq_r == S_DSTART);
  assign div_req.dividend = mag_r;
  assign div_req.divisor  = dvs_r;

  rccv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd1000;
      scenter_r <= 12'd1500;
      srange_r  <= 11'd500;
      tcenter_r <= 12'd1000;
      thr_idx_r <= 3'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data;
        CFG_SCENTER: scenter_r <= cfg_data[11:0];
        CFG_SRANGE:  srange_r  <= cfg_data[10:0];
        CFG_TCENTER: tcenter_r <= cfg_data[11:0];
        CFG_THR_IDX: thr_idx_r <= cfg_data[2:0];
        default:     timeout_r <= timeout_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      status_r    <= ST_OFF;
      fhv_r       <= 1'b0;
      silence_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        held_r[i] <= '0;
      end
    end else begin
      // The output step sets the valid flag itself when it loads a new word.
      if (!out_stall && seq_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (seq_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= action_t'(in_action);
            ch_r    <= in_channel;
            pulse_r <= in_pulse_us;
            fend_r  <= in_frame_end;
            seq_r   <= S_UPD;
          end
        end
        S_UPD: begin
          for (int i = 0; i < CHANNELS; i++) begin
            held_r[i] <= held_nxt[i];
          end
          status_r  <= status_nxt;
          fhv_r     <= fhv_nxt;
          silence_r <= silence_nxt;
          disarm_r  <= disarm_nxt;
          value_r   <= report_val;
          report_r  <= (status_nxt == ST_ON) && ch_ok;
          seq_r     <= S_MUL;
        end
        S_MUL: begin
          mag_r <= mag_nxt;
          neg_r <= prod[19];
          dvs_r <= dvs_nxt;
          seq_r <= S_DSTART;
        end
        S_DSTART: begin
          seq_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            seq_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_ch_r     <= ch_r;
            out_value_r  <= value_r;
            out_pct_r    <= pct;
            out_status_r <= status_r;
            out_disarm_r <= disarm_r;
            seq_r        <= S_IDLE;
          end
        end
        default: begin
          seq_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (seq_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_value_us    = out_value_r;
  assign out_percent     = out_pct_r;
  assign out_status      = out_status_r;
  assign out_disarm      = out_disarm_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rc_channel_validate_failsafe_top: a directed table, then
// random phases under several register settings, checked against the table's expected values or a built-in predictor.
// Depends on rccv_pkg and the top level only.
module tb_top;
  import rccv_pkg::*;

  localparam int NCH        = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 6;
  localparam int PHASE_WORDS = 100;

  typedef enum logic [2:0] {
    REG_TIMEOUT         = 3'd0,
    REG_STICK_CENTER    = 3'd1,
    REG_STICK_RANGE     = 3'd2,
    REG_THROTTLE_CENTER = 3'd3,
    REG_THROTTLE_INDEX  = 3'd4
  } reg_idx_t;

  typedef struct {
    logic [2:0]         ch;
    logic [11:0]        value;
    logic signed [7:0]  pct;
    status_t            status;
    logic               disarm;
  } rc_result_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    reg_sel;
    logic [15:0] cfg_val;
    action_t     act;
    logic [2:0]  ch;
    logic [11:0] pulse;
    logic        fe;
    int          reps;
    bit          typed;
    rc_result_t  want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [2:0]  in_channel;
  logic [11:0] in_pulse_us;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_channel_out;
  logic [11:0] out_value_us;
  logic signed [7:0] out_percent;
  logic [1:0]  out_status;
  logic        out_disarm;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  rc_channel_validate_failsafe_top #(.CHANNELS(NCH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .in_pulse_us     (in_pulse_us),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel_out (out_channel_out),
    .out_value_us    (out_value_us),
    .out_percent     (out_percent),
    .out_status      (out_status),
    .out_disarm      (out_disarm),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the receiver state and its registers.
  logic [11:0] held [NCH] = '{default: 12'd0};
  status_t     radio      = ST_OFF;
  logic        frame_live = 1'b0;
  logic [15:0] silence    = 16'd0;
  logic [15:0] fs_timeout   = 16'd1000;
  logic [11:0] stick_center = 12'd1500;
  logic [10:0] stick_range  = 11'd500;
  logic [11:0] thr_center   = 12'd1000;
  logic [2:0]  thr_index    = 3'd0;

  rc_result_t pending_results [$];
  plan_row_t  plan [$];
  bit calm = 1'b0;
  int errors = 0;
  int n_words = 0, n_live = 0, n_checked = 0, n_trips = 0, n_cfg = 0;
  int idle_cycles = 0;

  function automatic rc_result_t advance_radio(action_t act, logic [2:0] ch,
                                               logic [11:0] pulse, logic fe);
    rc_result_t r;
    int diff, span, q;
    r.ch = ch;
    r.value = 12'd0;
    r.pct = 8'sd0;
    r.disarm = 1'b0;
    case (act)
      ACT_PULSE: begin
        if (radio != ST_OFF) begin
          if (pulse >= PULSE_MIN_US && pulse <= PULSE_MAX_US) begin
            held[ch] = pulse;
            frame_live = 1'b1;
          end else if (held[ch] == 12'd0) begin
            held[ch] = (ch == thr_index) ? thr_center : stick_center;
          end
          if (fe) begin
            if (frame_live) begin
              silence = 16'd0;
              if (radio == ST_FAILSAFE) radio = ST_ON;
            end else if (silence > fs_timeout && radio != ST_FAILSAFE) begin
              radio = ST_FAILSAFE;
              held = '{default: 12'd0};
              r.disarm = 1'b1;
            end
            frame_live = 1'b0;
          end
        end
      end
      ACT_ON: begin
        if (radio == ST_OFF) begin
          radio = ST_ON;
          silence = 16'd0;
          frame_live = 1'b0;
        end
      end
      ACT_OFF: begin
        if (radio != ST_OFF) begin
          radio = ST_OFF;
          held = '{default: 12'd0};
          silence = 16'd0;
          frame_live = 1'b0;
        end
      end
      default: begin
        if (radio != ST_OFF && silence != 16'hFFFF) silence = silence + 16'd1;
      end
    endcase
    if (radio == ST_ON) begin
      r.value = held[ch];
      if (ch == thr_index) begin
        diff = int'(held[ch]) - int'(THROTTLE_ZERO_US);
        q = (diff * int'(FULL_PERCENT)) / int'(THROTTLE_SPAN_US);
        if (q < 0) q = 0;
        if (q > int'(FULL_PERCENT)) q = int'(FULL_PERCENT);
      end else begin
        diff = int'(held[ch]) - int'(stick_center);
        span = (stick_range == 11'd0) ? 1 : int'(stick_range);
        q = (diff * int'(FULL_PERCENT)) / span;
        if (q < -int'(FULL_PERCENT)) q = -int'(FULL_PERCENT);
        if (q > int'(FULL_PERCENT)) q = int'(FULL_PERCENT);
      end
      r.pct = 8'(q);
    end
    r.status = radio;
    return r;
  endfunction

  function automatic plan_row_t word(action_t act, int ch, int pulse, bit fe, int reps);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_sel = REG_TIMEOUT;
    row.cfg_val = 16'd0;
    row.act = act;
    row.ch = 3'(ch);
    row.pulse = 12'(pulse);
    row.fe = fe;
    row.reps = reps;
    row.typed = 1'b0;
    row.want = '{3'd0, 12'd0, 8'sd0, ST_OFF, 1'b0};
    return row;
  endfunction

  function automatic plan_row_t word_exp(action_t act, int ch, int pulse, bit fe,
                                         int val, int pct, status_t st, bit dis);
    plan_row_t row;
    row = word(act, ch, pulse, fe, 1);
    row.typed = 1'b1;
    row.want = '{3'(ch), 12'(val), 8'(pct), st, dis};
    return row;
  endfunction

  function automatic plan_row_t reg_write(reg_idx_t idx, int val);
    plan_row_t row;
    row = word(ACT_TICK, 0, 0, 1'b0, 0);
    row.is_cfg = 1'b1;
    row.reg_sel = idx;
    row.cfg_val = 16'(val);
    return row;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  // Waits at a falling edge; the caller drives the next word or lowers valid.
  task automatic send_word(action_t act, logic [2:0] ch, logic [11:0] pulse, logic fe,
                           bit typed, rc_result_t want);
    rc_result_t pred;
    bit live;
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_channel   <= ch;
    in_pulse_us  <= pulse;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall);
    live = (radio != ST_OFF) || (act == ACT_ON);
    pred = advance_radio(act, ch, pulse, fe);
    pending_results.push_back(typed ? want : pred);
    if (pred.disarm) n_trips++;
    if (live) n_live++;
    n_words++;
    @(negedge clk);
  endtask

  task automatic send_random(action_t act, logic [2:0] ch, logic [11:0] pulse, logic fe);
    rc_result_t none;
    send_word(act, ch, pulse, fe, 1'b0, none);
  endtask

  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TIMEOUT:         fs_timeout   = val;
      REG_STICK_CENTER:    stick_center = val[11:0];
      REG_STICK_RANGE:     stick_range  = val[10:0];
      REG_THROTTLE_CENTER: thr_center   = val[11:0];
      default:             thr_index    = val[2:0];
    endcase
    n_cfg++;
    @(negedge clk);
  endtask

  function automatic logic [11:0] bad_pulse();
    return ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 799))
                                       : 12'($urandom_range(2201, 4095));
  endfunction

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk) begin : check_results
    rc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, channel", int'(out_channel_out), -1);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_channel_out !== e.ch)
          report_mismatch("channel_out", int'(out_channel_out), int'(e.ch));
        if (out_value_us !== e.value)
          report_mismatch("value_us", int'(out_value_us), int'(e.value));
        if (out_percent !== e.pct)
          report_mismatch("percent", int'(out_percent), int'(e.pct));
        if (out_status !== e.status)
          report_mismatch("status", int'(out_status), int'(e.status));
        if (out_disarm !== e.disarm)
          report_mismatch("disarm", int'(out_disarm), int'(e.disarm));
      end
    end
  end

  // Ends a run that has stopped moving on the input, output and register interfaces.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[rc_channel_validate_failsafe_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int start, pick, n;
    bit silent;
    logic [11:0] p;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_PULSE;
    in_channel   = 3'd0;
    in_pulse_us  = 12'd0;
    in_frame_end = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_TIMEOUT;
    cfg_data     = 16'd0;

    plan = '{
      word_exp(ACT_PULSE, 0, 1500, 1'b0, 0, 0, ST_OFF, 1'b0),
      word_exp(ACT_TICK, 3, 0, 1'b0, 0, 0, ST_OFF, 1'b0),
      word_exp(ACT_OFF, 0, 0, 1'b0, 0, 0, ST_OFF, 1'b0),
      word_exp(ACT_ON, 1, 0, 1'b0, 0, -100, ST_ON, 1'b0),
      word_exp(ACT_ON, 0, 0, 1'b0, 0, 0, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 0, 800, 1'b0, 800, 0, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 0, 2200, 1'b0, 2200, 100, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 1, 2200, 1'b0, 2200, 100, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 2, 800, 1'b0, 800, -100, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 3, 799, 1'b0, 1500, 0, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 3, 2201, 1'b0, 1500, 0, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 4, 4095, 1'b1, 1500, 0, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 5, 0, 1'b1, 1500, 0, ST_ON, 1'b0),
      word(ACT_PULSE, 1, 1496, 1'b0, 1),
      word(ACT_PULSE, 2, 1994, 1'b1, 1),
      // Silence exactly at the default timeout must not trip; one more tick does.
      word(ACT_TICK, 0, 0, 1'b0, 1000),
      word_exp(ACT_PULSE, 5, 0, 1'b1, 1500, 0, ST_ON, 1'b0),
      word(ACT_TICK, 0, 0, 1'b0, 1),
      word_exp(ACT_PULSE, 6, 4095, 1'b1, 0, 0, ST_FAILSAFE, 1'b1),
      word_exp(ACT_PULSE, 6, 300, 1'b1, 0, 0, ST_FAILSAFE, 1'b0),
      word_exp(ACT_ON, 0, 0, 1'b0, 0, 0, ST_FAILSAFE, 1'b0),
      word_exp(ACT_TICK, 0, 0, 1'b0, 0, 0, ST_FAILSAFE, 1'b0),
      word_exp(ACT_PULSE, 0, 1200, 1'b0, 0, 0, ST_FAILSAFE, 1'b0),
      word_exp(ACT_PULSE, 7, 900, 1'b1, 900, -100, ST_ON, 1'b0),
      word_exp(ACT_OFF, 2, 0, 1'b0, 0, 0, ST_OFF, 1'b0),
      word_exp(ACT_ON, 2, 0, 1'b0, 0, -100, ST_ON, 1'b0),
      word_exp(ACT_PULSE, 0, 100, 1'b0, 1000, 0, ST_ON, 1'b0),
      reg_write(REG_STICK_RANGE, 0),
      word(ACT_PULSE, 1, 1501, 1'b0, 1),
      word(ACT_PULSE, 2, 1499, 1'b1, 1)
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle(4);
        write_reg(plan[i].reg_sel, plan[i].cfg_val);
        cfg_valid <= 1'b0;
      end else begin
        for (int r = 0; r < plan[i].reps; r++)
          send_word(plan[i].act, plan[i].ch, plan[i].pulse, plan[i].fe,
                    plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle(4);
      calm = (ph == 1);
      if (ph == 0) begin
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_STICK_CENTER, 16'd800);
        write_reg(REG_STICK_RANGE, 16'd1);
        write_reg(REG_THROTTLE_CENTER, 16'd800);
        write_reg(REG_THROTTLE_INDEX, 16'd0);
      end else if (ph == 1) begin
        write_reg(REG_TIMEOUT, 16'd65534);
        write_reg(REG_STICK_CENTER, 16'd2200);
        write_reg(REG_STICK_RANGE, 16'd1400);
        write_reg(REG_THROTTLE_CENTER, 16'd2200);
        write_reg(REG_THROTTLE_INDEX, 16'd7);
      end else begin
        write_reg(REG_TIMEOUT, 16'($urandom_range(0, 25)));
        write_reg(REG_STICK_CENTER, 16'($urandom_range(800, 2200)));
        write_reg(REG_STICK_RANGE, 16'($urandom_range(1, 1400)));
        write_reg(REG_THROTTLE_CENTER, 16'($urandom_range(800, 2200)));
        write_reg(REG_THROTTLE_INDEX, 16'($urandom_range(0, 7)));
      end
      cfg_valid <= 1'b0;
      send_random(ACT_ON, 3'($urandom_range(0, 7)), 12'($urandom), 1'($urandom));
      start = n_live;
      while (n_live - start < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // A frame of consecutive channels; silent frames push toward failsafe.
          silent = $urandom_range(0, 99) < 35;
          n = $urandom_range(1, NCH);
          for (int k = 0; k < n; k++) begin
            if (silent || $urandom_range(0, 9) == 0) p = bad_pulse();
            else p = 12'($urandom_range(800, 2200));
            send_random(ACT_PULSE, ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(k),
                        p, k == n - 1);
          end
        end else if (pick < 80) begin
          n = $urandom_range(1, 12);
          repeat (n) send_random(ACT_TICK, 3'($urandom), 12'($urandom), 1'($urandom));
        end else if (pick < 85) begin
          send_random(ACT_OFF, 3'($urandom), 12'($urandom), 1'($urandom));
          send_random(ACT_ON, 3'($urandom), 12'($urandom), 1'($urandom));
        end else begin
          send_random(action_t'($urandom_range(0, 3)), 3'($urandom), 12'($urandom),
                      1'($urandom));
        end
      end
    end

    settle(30);
    $display("Sent %0d words (%0d with the radio powered), checked %0d results.",
             n_words, n_live, n_checked);
    $display("Saw %0d failsafe entries over %0d register writes; %0d mismatches.",
             n_trips, n_cfg, errors);
    if (errors == 0)
      $display("[rc_channel_validate_failsafe_top] OK");
    else
      $display("[rc_channel_validate_failsafe_top] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/rccv_pkg.sv
rtl/rccv_div.sv
rtl/rc_channel_validate_failsafe_top.sv
tb/tb_top.sv
